FILE: sv/lsd_pkg.sv
// Shared constants, types and control structs for the LZSS stream decoder.
package lsd_pkg;

	localparam int WINDOW_BYTES = 4096;
	localparam int AW           = $clog2(WINDOW_BYTES);
	localparam int MAX_MATCH    = 18;
	localparam int LW           = $clog2(MAX_MATCH + 1);
	localparam int IW           = $clog2(MAX_MATCH);
	localparam int MIN_MATCH    = 3;
	localparam int TOKENS       = 8;
	localparam int TW           = $clog2(TOKENS + 1);

	localparam logic [7:0] FILL_BYTE = 8'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LIT,
		KIND_PAIR
	} kind_t;

	typedef struct packed {
		logic take;
		logic rd_issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  rd_last;
		logic  em_last;
		logic  out_free;
	} sts_t;

endpackage

FILE: sv/lzss_stream_decoder_core.sv
// Top level of the LZSS stream decoder (4096-byte window).
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  s_      | in  | s_tvalid/tready  | s_tdata: in_byte; s_tuser: new_stream
//  m_      | out | m_tvalid/tready  | m_tdata: out_byte; m_tlast: last_of_run
//
// Flag bytes and the first byte of a pair are only taken; a literal is emitted,
// and the second byte of a pair starts a copy of len = 3..18 bytes: the single
// window read port sweeps all source bytes into the copy buffer first, then the
// write port stores them back one per cycle while they are emitted, unless stalled.
// Reset: no clearing pass; since window writes run contiguously from 0, an
// address at or beyond the write pointer (before first wrap) reads as space.
// Stalls: m_tready low freezes the emit sweep; a result held in the output
// register does not block acceptance of flag or pair-offset bytes.
module lzss_stream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] new_stream
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // last_of_run
);

	lsd_pkg::cmd_t cmd;
	lsd_pkg::sts_t sts;

	// sequencing: idle / window read sweep / emit-and-write sweep
	lsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser state, window, copy buffer, output register
	lsd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.new_stream (s_tuser),
		.in_byte    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: sv/lsd_ctrl.sv
// Controller state machine: input acceptance, window read sweep, emit/write sweep.
module lsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lsd_pkg::sts_t sts,
	output lsd_pkg::cmd_t cmd
);

	lsd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (sts.kind)
						lsd_pkg::KIND_LIT:  state_d = lsd_pkg::ST_EMIT;
						lsd_pkg::KIND_PAIR: state_d = lsd_pkg::ST_READ;
						default:            state_d = lsd_pkg::ST_IDLE;
					endcase
				end
			end
			lsd_pkg::ST_READ: begin
				if (sts.rd_last) begin
					state_d = lsd_pkg::ST_EMIT;
				end
			end
			lsd_pkg::ST_EMIT: begin
				if (sts.out_free && sts.em_last) begin
					state_d = lsd_pkg::ST_IDLE;
				end
			end
			default: state_d = lsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		case (state_q)
			lsd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			lsd_pkg::ST_READ: begin
				cmd.rd_issue = 1'b1;
			end
			lsd_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/lsd_datapath.sv
// Datapath: token parsing, window memory, copy buffer and output register.
module lsd_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  lsd_pkg::cmd_t cmd,
	output lsd_pkg::sts_t sts,
	input  logic          new_stream,
	input  logic [7:0]    in_byte,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);

	// window and fill tracking: writes run contiguously from 0, so an entry
	// is written once wrap_q is set or its address is below wpos_q
	logic [7:0]              win_q [lsd_pkg::WINDOW_BYTES];
	logic [lsd_pkg::AW-1:0]  wpos_q;
	logic                    wrap_q;

	// token parser state
	logic [7:0]              flag_q;
	logic [lsd_pkg::TW-1:0]  tok_q;
	logic                    await_q;
	logic [7:0]              ohigh_q;

	// copy job
	logic [lsd_pkg::AW-1:0]  src_q;
	logic [lsd_pkg::LW-1:0]  len_q;
	logic [lsd_pkg::IW-1:0]  rd_idx_q;
	logic [lsd_pkg::IW-1:0]  em_idx_q;
	logic [7:0]              copy_q [lsd_pkg::MAX_MATCH];

	// read pipeline
	logic                    rd_v_s1;
	logic [7:0]              rd_data_s1;
	logic                    rd_ok_s1;
	logic [lsd_pkg::IW-1:0]  rd_idx_s1;

	logic                    m_tvalid_q;
	logic [7:0]              m_tdata_q;
	logic                    m_tlast_q;

	logic [7:0]              flag_e;
	logic [lsd_pkg::TW-1:0]  tok_e;
	logic                    await_e;
	logic                    is_hi;
	lsd_pkg::kind_t          kind;
	logic [lsd_pkg::AW-1:0]  rd_addr;
	logic                    rd_ok;
	logic                    out_free;
	logic                    em_last;
	logic [lsd_pkg::LW-1:0]  len_m1;

	// a new stream clears parser state before the byte is looked at
	assign flag_e  = new_stream ? 8'h00 : flag_q;
	assign tok_e   = new_stream ? '0 : tok_q;
	assign await_e = new_stream ? 1'b0 : await_q;

	assign is_hi = (tok_e != '0) && !await_e && !flag_e[0];

	always_comb begin
		if (tok_e == '0) begin
			kind = lsd_pkg::KIND_NONE;
		end else if (await_e) begin
			kind = lsd_pkg::KIND_PAIR;
		end else if (flag_e[0]) begin
			kind = lsd_pkg::KIND_LIT;
		end else begin
			kind = lsd_pkg::KIND_NONE;
		end
	end

	assign rd_addr  = src_q + lsd_pkg::AW'(rd_idx_q);
	assign rd_ok    = wrap_q || (rd_addr < wpos_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign len_m1   = len_q - lsd_pkg::LW'(1);
	assign em_last  = lsd_pkg::LW'(em_idx_q) == len_m1;

	assign sts.kind     = kind;
	assign sts.rd_last  = lsd_pkg::LW'(rd_idx_q) == len_m1;
	assign sts.em_last  = em_last;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			wrap_q   <= 1'b0;
			flag_q   <= '0;
			tok_q    <= '0;
			await_q  <= 1'b0;
			rd_idx_q <= '0;
			em_idx_q <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_issue;
			if (cmd.take) begin
				rd_idx_q <= '0;
				em_idx_q <= '0;
				if (new_stream) begin
					wpos_q <= '0;
					wrap_q <= 1'b0;
				end
				if (tok_e == '0) begin
					flag_q  <= in_byte;
					tok_q   <= lsd_pkg::TW'(lsd_pkg::TOKENS);
					await_q <= 1'b0;
				end else if (await_e || flag_e[0]) begin
					flag_q  <= flag_e >> 1;
					tok_q   <= tok_e - lsd_pkg::TW'(1);
					await_q <= 1'b0;
				end else begin
					flag_q  <= flag_e;
					tok_q   <= tok_e;
					await_q <= 1'b1;
				end
			end
			if (cmd.rd_issue) begin
				rd_idx_q <= rd_idx_q + lsd_pkg::IW'(1);
			end
			if (cmd.emit) begin
				em_idx_q <= em_idx_q + lsd_pkg::IW'(1);
				wpos_q   <= wpos_q + lsd_pkg::AW'(1);
				if (&wpos_q) begin
					wrap_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (is_hi) begin
				ohigh_q <= in_byte;
			end
			if (kind == lsd_pkg::KIND_PAIR) begin
				src_q <= {ohigh_q, in_byte[7:4]};
				len_q <= lsd_pkg::LW'(in_byte[3:0]) + lsd_pkg::LW'(lsd_pkg::MIN_MATCH);
			end else if (kind == lsd_pkg::KIND_LIT) begin
				len_q     <= lsd_pkg::LW'(1);
				copy_q[0] <= in_byte;
			end
		end
		if (rd_v_s1) begin
			copy_q[rd_idx_s1] <= rd_ok_s1 ? rd_data_s1 : lsd_pkg::FILL_BYTE;
		end
	end

	// window memory: one write port (emit), one registered read port (sweep)
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			win_q[wpos_q] <= copy_q[em_idx_q];
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= win_q[rd_addr];
			rd_ok_s1   <= rd_ok;
			rd_idx_s1  <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= copy_q[em_idx_q];
			m_tlast_q <= em_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: sv/lsd_checker.sv
// Port-level checker for the LZSS stream decoder, bound to the top level.
module lsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic in_xfer;

	assign in_xfer = s_tvalid && s_tready;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// no result can appear in the cycle right after an input transfer
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !$rose(m_tvalid))
		else $error("result appeared too early after input transfer");

	// inside a multi-byte run, input stays blocked
	a_run_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during a copy run");

	// a stream restart byte is a flag byte: block is ready again at once
	a_restart_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tuser |=> s_tready)
		else $error("not ready after stream restart byte");

endmodule

bind lzss_stream_decoder_core lsd_checker u_lsd_checker (.*);
